[hw/rtl/fbrl_pkg.sv]
// Shared types and constants for the framebuffer rectangle and line drawer.
// Used by every module of the block; depends on nothing.
`default_nettype none
package fbrl_pkg;

	localparam int CoordBits  = 13;
	localparam int WideBits   = CoordBits + 1;
	localparam int ProdBits   = 2 * CoordBits + 1;
	localparam int AddrBits   = 48;
	localparam int PitchBits  = 16;
	localparam int ColorBits  = 32;
	localparam int QueueDepth = 2;
	localparam int PaddrBits  = 6;
	localparam int PdataBits  = 64;

	typedef enum logic [1:0] {
		CMD_RECT = 2'd0,
		CMD_LINE = 2'd1,
		CMD_STEP = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_RECT,
		OP_LINE,
		OP_STEP,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_RECT,
		KIND_VERT,
		KIND_SLOPE
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_YSUM,
		S_ADDR,
		S_SUM,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		REG_BASE   = 3'd0,
		REG_PITCH  = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_PIXB   = 3'd4,
		REG_RED    = 3'd5,
		REG_GREEN  = 3'd6,
		REG_BLUE   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]           command;
		logic [CoordBits-1:0] point_x;
		logic [CoordBits-1:0] point_y;
		logic [CoordBits-1:0] far_x;
		logic [CoordBits-1:0] far_y;
		logic [7:0]           red;
		logic [7:0]           green;
		logic [7:0]           blue;
	} in_item_t;

	typedef struct packed {
		logic                 write_valid;
		logic [AddrBits-1:0]  write_address;
		logic [ColorBits-1:0] pixel_value;
		logic                 walk_busy;
		logic                 shape_last;
	} out_item_t;

	typedef struct packed {
		logic [AddrBits-1:0]  base_address;
		logic [PitchBits-1:0] line_pitch;
		logic [CoordBits-1:0] screen_width;
		logic [CoordBits-1:0] screen_height;
		logic [2:0]           pixel_bytes;
		logic [4:0]           red_shift;
		logic [4:0]           green_shift;
		logic [4:0]           blue_shift;
	} cfg_t;

	typedef struct packed {
		op_t                  op;
		logic [CoordBits-1:0] px;
		logic [CoordBits-1:0] py;
		logic [CoordBits-1:0] fx;
		logic [CoordBits-1:0] fy;
		logic [ColorBits-1:0] color;
	} entry_t;

endpackage
`default_nettype wire

[hw/rtl/fbrl_front.sv]
// Front end: takes input beats, classifies the command and packs the colour.
// Depends on fbrl_pkg; feeds fbrl_queue.
`default_nettype none
module fbrl_front (
	input  wire fbrl_pkg::in_item_t in_item,
	input  wire fbrl_pkg::cfg_t     cfg,
	output fbrl_pkg::entry_t        entry
);
	import fbrl_pkg::*;

	logic [63:0] packed_v;

	always_comb begin
		packed_v = (64'(in_item.red) << cfg.red_shift) |
			(64'(in_item.green) << cfg.green_shift) |
			(64'(in_item.blue) << cfg.blue_shift);
		entry.px    = in_item.point_x;
		entry.py    = in_item.point_y;
		entry.fx    = in_item.far_x;
		entry.fy    = in_item.far_y;
		entry.color = packed_v[ColorBits-1:0];
		unique case (cmd_t'(in_item.command))
			CMD_RECT: entry.op = OP_RECT;
			CMD_LINE: entry.op = OP_LINE;
			CMD_STEP: entry.op = OP_STEP;
			CMD_NONE: entry.op = OP_NOP;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/fbrl_queue.sv]
// Short queue of classified commands between the front end and the walker.
// Depends on fbrl_pkg.
`default_nettype none
module fbrl_queue #(
	parameter int Depth = fbrl_pkg::QueueDepth
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire fbrl_pkg::entry_t push_entry,
	output logic                  full,
	input  wire                   pop,
	output logic                  head_valid,
	output fbrl_pkg::entry_t      head
);
	import fbrl_pkg::*;

	localparam int IdxBits = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntBits = $clog2(Depth + 1);
	localparam logic [IdxBits-1:0] LastIdx = IdxBits'(Depth - 1);

	entry_t               mem_q [Depth];
	logic [IdxBits-1:0]   wr_q, rd_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 do_push, do_pop;

	assign full       = (cnt_q == CntBits'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_entry;
	end

endmodule
`default_nettype wire

[hw/rtl/fbrl_back.sv]
// Back end: shape walker with an iterative divider for sloped lines, the
// address arithmetic and the output register. Depends on fbrl_pkg.
`default_nettype none
module fbrl_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire fbrl_pkg::cfg_t   cfg,
	input  wire                   head_valid,
	input  wire fbrl_pkg::entry_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_stall,
	output fbrl_pkg::out_item_t   out_item
);
	import fbrl_pkg::*;

	localparam int CntBits = $clog2(ProdBits + 1);
	localparam int YBits   = WideBits + 1;

	state_t state_q, state_d;

	kind_t                kind_q;
	logic [WideBits-1:0]  cx_q, cy_q, lim_x_q, lim_y_q, dx_q, dy_q;
	logic [CoordBits-1:0] row_q, ox_q, oy_q;
	logic                 vdir_q;
	logic [ColorBits-1:0] color_q;

	logic [ProdBits-1:0]  qr_q;
	logic [CoordBits-1:0] rem_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 neg_q;
	logic [WideBits-1:0]  ex_q;
	logic [YBits-1:0]     ey_q;
	logic                 on_q;
	logic [CoordBits+PitchBits-1:0] ypitch_q;
	logic [CoordBits+2:0] xoff_q;
	logic [AddrBits-1:0]  addr_q;

	logic                 out_valid_q;
	out_item_t            out_item_q;

	logic                 out_free, step_active, finish;
	logic [WideBits-1:0]  dy_abs, n_off;
	logic [CoordBits:0]   trial;
	logic                 trial_ok;
	logic [YBits-1:0]     y_sum;
	logic [WideBits-1:0]  lx, ly, nx, ny;
	logic                 on_d;
	logic [ColorBits-1:0] val_masked;
	out_item_t            res;
	kind_t                kind_d;
	logic                 last;

	assign out_free    = !out_valid_q || !out_stall;
	assign step_active = head.op == OP_STEP && kind_q != KIND_IDLE;
	assign out_valid   = out_valid_q;
	assign out_item    = out_item_q;

	// divider datapath
	assign dy_abs   = dy_q[WideBits-1] ? WideBits'(-dy_q) : dy_q;
	assign n_off    = cx_q - {1'b0, ox_q};
	assign trial    = {rem_q, qr_q[ProdBits-1]};
	assign trial_ok = trial >= {1'b0, dx_q[CoordBits-1:0]};
	assign y_sum    = {2'b00, oy_q} +
		(neg_q ? YBits'(-{1'b0, qr_q[WideBits-1:0]}) : {1'b0, qr_q[WideBits-1:0]});

	assign on_d = !ey_q[YBits-1] && ex_q < {1'b0, cfg.screen_width} &&
		ey_q[WideBits-1:0] < {1'b0, cfg.screen_height};

	always_comb begin
		unique case (cfg.pixel_bytes)
			3'd0:    val_masked = '0;
			3'd1:    val_masked = {24'b0, color_q[7:0]};
			3'd2:    val_masked = {16'b0, color_q[15:0]};
			3'd3:    val_masked = {8'b0, color_q[23:0]};
			default: val_masked = color_q;
		endcase
	end

	// clamped rectangle limits for a start beat
	always_comb begin
		lx = {1'b0, head.px} + {1'b0, head.fx};
		ly = {1'b0, head.py} + {1'b0, head.fy};
		if (lx > {1'b0, cfg.screen_width})  lx = {1'b0, cfg.screen_width};
		if (ly > {1'b0, cfg.screen_height}) ly = {1'b0, cfg.screen_height};
		nx = cx_q + 1'b1;
		ny = cy_q + 1'b1;
	end

	// result and next walker kind for the beat at the head
	always_comb begin
		res    = '0;
		kind_d = kind_q;
		last   = 1'b0;
		priority if (head.op == OP_RECT) begin
			kind_d = ({1'b0, head.px} < lx && {1'b0, head.py} < ly) ? KIND_RECT : KIND_IDLE;
		end else if (head.op == OP_LINE) begin
			if (head.px == head.fx)     kind_d = KIND_VERT;
			else if (head.px < head.fx) kind_d = KIND_SLOPE;
			else                        kind_d = KIND_IDLE;
		end else if (step_active) begin
			unique case (kind_q)
				KIND_RECT:  last = nx >= lim_x_q && ny >= lim_y_q;
				KIND_VERT:  last = cy_q == lim_y_q;
				KIND_SLOPE: last = cx_q >= lim_x_q;
				KIND_IDLE:  last = 1'b0;
			endcase
			if (last) kind_d = KIND_IDLE;
			res.write_valid   = on_q;
			res.write_address = on_q ? addr_q : '0;
			res.pixel_value   = on_q ? val_masked : '0;
			res.shape_last    = last;
		end
		if (head.op != OP_STEP && head.op != OP_NOP) res.walk_busy = kind_d != KIND_IDLE;
		else if (step_active) res.walk_busy = kind_d != KIND_IDLE;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					if (step_active && kind_q == KIND_SLOPE) state_d = S_MUL;
					else if (step_active) state_d = S_ADDR;
					else state_d = S_DONE;
				end
			end
			S_MUL:  state_d = S_DIV;
			S_DIV:  if (cnt_q == CntBits'(ProdBits - 1)) state_d = S_YSUM;
			S_YSUM: state_d = S_ADDR;
			S_ADDR: state_d = S_SUM;
			S_SUM:  state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		finish = state_q == S_DONE && out_free;
		pop    = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_IDLE;
			cx_q <= '0; cy_q <= '0; lim_x_q <= '0; lim_y_q <= '0;
			dx_q <= '0; dy_q <= '0; row_q <= '0; ox_q <= '0; oy_q <= '0;
			vdir_q <= 1'b0; color_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_free) out_valid_q <= finish;
			if (finish) begin
				kind_q <= kind_d;
				priority if (head.op == OP_RECT) begin
					color_q <= head.color;
					if (kind_d == KIND_RECT) begin
						cx_q <= {1'b0, head.px}; cy_q <= {1'b0, head.py};
						row_q <= head.px; lim_x_q <= lx; lim_y_q <= ly;
					end
				end else if (head.op == OP_LINE) begin
					color_q <= head.color;
					if (kind_d == KIND_VERT) begin
						ox_q <= head.px; oy_q <= head.py;
						cx_q <= {1'b0, head.px}; cy_q <= {1'b0, head.py};
						lim_y_q <= {1'b0, head.fy};
						vdir_q <= head.py > head.fy;
					end else if (kind_d == KIND_SLOPE) begin
						ox_q <= head.px; oy_q <= head.py;
						cx_q <= {1'b0, head.px}; lim_x_q <= {1'b0, head.fx};
						dx_q <= {1'b0, head.fx} - {1'b0, head.px};
						dy_q <= {1'b0, head.fy} - {1'b0, head.py};
					end
				end else if (step_active) begin
					unique case (kind_q)
						KIND_RECT: begin
							if (nx >= lim_x_q) begin
								cx_q <= {1'b0, row_q};
								cy_q <= ny;
							end else begin
								cx_q <= nx;
							end
						end
						KIND_VERT: begin
							if (!last) cy_q <= vdir_q ? cy_q - 1'b1 : ny;
						end
						KIND_SLOPE: if (!last) cx_q <= nx;
						KIND_IDLE: ;
					endcase
				end
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ex_q <= (kind_q == KIND_VERT) ? {1'b0, ox_q} : cx_q;
				ey_q <= {1'b0, cy_q};
			end
			S_MUL: begin
				qr_q  <= ProdBits'(dy_abs) * ProdBits'(n_off[CoordBits-1:0]);
				neg_q <= dy_q[WideBits-1];
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				// one quotient bit a cycle, restoring
				rem_q <= trial_ok ? CoordBits'(trial - {1'b0, dx_q[CoordBits-1:0]})
					: trial[CoordBits-1:0];
				qr_q  <= {qr_q[ProdBits-2:0], trial_ok};
				cnt_q <= cnt_q + 1'b1;
			end
			S_YSUM: begin
				ex_q <= cx_q;
				ey_q <= y_sum;
			end
			S_ADDR: begin
				on_q     <= on_d;
				ypitch_q <= (CoordBits+PitchBits)'(ey_q[CoordBits-1:0]) *
					(CoordBits+PitchBits)'(cfg.line_pitch);
				xoff_q   <= (CoordBits+3)'(ex_q[CoordBits-1:0]) *
					(CoordBits+3)'(cfg.pixel_bytes);
			end
			S_SUM: begin
				addr_q <= cfg.base_address + AddrBits'(ypitch_q) + AddrBits'(xoff_q);
			end
			S_DONE: if (finish && out_free) out_item_q <= res;
			default: ;
		endcase
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < CntBits'(ProdBits))
		else $error("divider count overran");

	a_last_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.shape_last |-> !out_item_q.walk_busy)
		else $error("final pixel beat still reports busy");

	a_done_pops: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == S_DONE) && state_q == S_IDLE |-> $past(pop))
		else $error("left done state without retiring the command");

	a_quiet_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_item_q.write_valid |-> out_item_q.write_address == '0)
		else $error("suppressed pixel carries an address");

endmodule
`default_nettype wire

[hw/rtl/framebuffer_rect_and_line_drawer.sv]
// Rectangle fill and line walker for a linear framebuffer. Start beats
// (rectangle or line) latch a shape and colour; each step beat yields one
// pixel write at base + y*pitch + x*pixel_bytes, off-screen pixels
// suppressed. Commands pass through a two-entry queue, so the input side
// keeps taking beats while the walker works and the output register waits.
// A start or idle step passes straight to the done state; a rectangle or vertical
// line step goes through the address and sum stages, and a sloped line step first
// through the multiply stage, the radix-2 restoring divider (27 bits, one quotient
// bit per cycle) and the y sum. Registers sit at byte addresses 8*i on the
// 64-bit configuration port. Depends on fbrl_pkg and its submodules.
`default_nettype none
module framebuffer_rect_and_line_drawer #(
	parameter int QueueDepth = fbrl_pkg::QueueDepth
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire fbrl_pkg::in_item_t        in_item,
	output logic                           out_valid,
	input  wire                            out_stall,
	output fbrl_pkg::out_item_t            out_item,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [fbrl_pkg::PaddrBits-1:0]  paddr,
	input  wire [fbrl_pkg::PdataBits-1:0]  pwdata,
	output logic [fbrl_pkg::PdataBits-1:0] prdata,
	output logic                           pready
);
	import fbrl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	entry_t   entry, head;
	logic     q_full, head_valid, pop;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address  <= '0;
			cfg_q.line_pitch    <= '0;
			cfg_q.screen_width  <= '0;
			cfg_q.screen_height <= '0;
			cfg_q.pixel_bytes   <= 3'd4;
			cfg_q.red_shift     <= 5'd16;
			cfg_q.green_shift   <= 5'd8;
			cfg_q.blue_shift    <= 5'd0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BASE:   cfg_q.base_address  <= pwdata[AddrBits-1:0];
				REG_PITCH:  cfg_q.line_pitch    <= pwdata[PitchBits-1:0];
				REG_WIDTH:  cfg_q.screen_width  <= pwdata[CoordBits-1:0];
				REG_HEIGHT: cfg_q.screen_height <= pwdata[CoordBits-1:0];
				REG_PIXB:   cfg_q.pixel_bytes   <= pwdata[2:0];
				REG_RED:    cfg_q.red_shift     <= pwdata[4:0];
				REG_GREEN:  cfg_q.green_shift   <= pwdata[4:0];
				REG_BLUE:   cfg_q.blue_shift    <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BASE:   prdata = PdataBits'(cfg_q.base_address);
			REG_PITCH:  prdata = PdataBits'(cfg_q.line_pitch);
			REG_WIDTH:  prdata = PdataBits'(cfg_q.screen_width);
			REG_HEIGHT: prdata = PdataBits'(cfg_q.screen_height);
			REG_PIXB:   prdata = PdataBits'(cfg_q.pixel_bytes);
			REG_RED:    prdata = PdataBits'(cfg_q.red_shift);
			REG_GREEN:  prdata = PdataBits'(cfg_q.green_shift);
			REG_BLUE:   prdata = PdataBits'(cfg_q.blue_shift);
		endcase
	end

	assign in_stall = q_full;

	fbrl_front u_front (
		.in_item (in_item),
		.cfg     (cfg_q),
		.entry   (entry)
	);

	fbrl_queue #(.Depth(QueueDepth)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_entry (entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fbrl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for framebuffer_rect_and_line_drawer: drives command beats,
// programs the APB registers between phases and compares every pixel beat with a predictor.
// Depends on fbrl_pkg and the drawer RTL.
module testbench;
	import fbrl_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic psel, penable, pwrite;
	logic [PaddrBits-1:0] paddr;
	logic [PdataBits-1:0] pwdata;
	logic [PdataBits-1:0] prdata;
	logic pready;

	framebuffer_rect_and_line_drawer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor copy of registers and walker state
	cfg_t cfg;
	kind_t walk;
	logic [WideBits-1:0] cur_x, cur_y, lim_x, lim_y, dx_run, dy_rise;
	logic [CoordBits-1:0] row_x0, org_x, org_y;
	logic upward;
	logic [ColorBits-1:0] color;

	out_item_t pixel_queue[$];
	int errors;
	int cycles;
	bit stall_quiet;

	task automatic reset_model();
		cfg = '0;
		cfg.pixel_bytes = 3'd4;
		cfg.red_shift = 5'd16;
		cfg.green_shift = 5'd8;
		walk = KIND_IDLE;
		cur_x = '0; cur_y = '0; lim_x = '0; lim_y = '0; dx_run = '0; dy_rise = '0;
		row_x0 = '0; org_x = '0; org_y = '0; upward = 1'b0; color = '0;
	endtask

	function automatic out_item_t draw_pixel(longint x, longint y);
		out_item_t r;
		logic [63:0] a;
		r = '0;
		if (x >= longint'(cfg.screen_width) || y >= longint'(cfg.screen_height))
			return r;
		a = 64'(cfg.base_address) + 64'(y) * 64'(cfg.line_pitch) +
			64'(x) * 64'(cfg.pixel_bytes);
		r.write_valid = 1'b1;
		r.write_address = a[AddrBits-1:0];
		if (cfg.pixel_bytes >= 3'd4)
			r.pixel_value = color;
		else
			r.pixel_value = color & ((32'd1 << (32'(cfg.pixel_bytes) * 8)) - 32'd1);
		return r;
	endfunction

	function automatic out_item_t predict_pixel(in_item_t it);
		out_item_t r;
		logic [63:0] packed_rgb;
		logic [WideBits-1:0] lx, ly;
		longint dy, dx, y;
		bit last;
		r = '0;
		last = 0;
		if (it.command == CMD_RECT || it.command == CMD_LINE) begin
			packed_rgb = (64'(it.red) << cfg.red_shift) | (64'(it.green) << cfg.green_shift)
				| (64'(it.blue) << cfg.blue_shift);
			color = packed_rgb[31:0];
			walk = KIND_IDLE;
			if (it.command == CMD_RECT) begin
				lx = WideBits'(it.point_x) + WideBits'(it.far_x);
				ly = WideBits'(it.point_y) + WideBits'(it.far_y);
				if (lx > WideBits'(cfg.screen_width)) lx = WideBits'(cfg.screen_width);
				if (ly > WideBits'(cfg.screen_height)) ly = WideBits'(cfg.screen_height);
				if (WideBits'(it.point_x) < lx && WideBits'(it.point_y) < ly) begin
					walk = KIND_RECT;
					cur_x = WideBits'(it.point_x); cur_y = WideBits'(it.point_y);
					row_x0 = it.point_x;
					lim_x = lx; lim_y = ly;
				end
			end else if (it.point_x == it.far_x) begin
				walk = KIND_VERT;
				org_x = it.point_x; org_y = it.point_y;
				cur_x = WideBits'(it.point_x); cur_y = WideBits'(it.point_y);
				lim_y = WideBits'(it.far_y);
				upward = it.point_y > it.far_y;
			end else if (it.point_x < it.far_x) begin
				walk = KIND_SLOPE;
				org_x = it.point_x; org_y = it.point_y;
				cur_x = WideBits'(it.point_x); lim_x = WideBits'(it.far_x);
				dx_run = WideBits'(it.far_x) - WideBits'(it.point_x);
				dy_rise = WideBits'(it.far_y) - WideBits'(it.point_y);
			end
			r.walk_busy = walk != KIND_IDLE;
			return r;
		end
		if (it.command != CMD_STEP || walk == KIND_IDLE)
			return r;
		case (walk)
			KIND_RECT: begin
				r = draw_pixel(longint'(cur_x), longint'(cur_y));
				cur_x = cur_x + 1'b1;
				if (cur_x >= lim_x) begin
					cur_x = WideBits'(row_x0);
					cur_y = cur_y + 1'b1;
					if (cur_y >= lim_y) last = 1;
				end
			end
			KIND_VERT: begin
				r = draw_pixel(longint'(org_x), longint'(cur_y));
				if (cur_y == lim_y) last = 1;
				else if (upward) cur_y = cur_y - 1'b1;
				else cur_y = cur_y + 1'b1;
			end
			default: begin
				dy = longint'($signed(dy_rise));
				dx = longint'(dx_run);
				if (dx == 0) dx = 1;
				y = longint'(org_y) +
					(dy * longint'(WideBits'(cur_x - WideBits'(org_x)))) / dx;
				if (y >= 0) r = draw_pixel(longint'(cur_x), y);
				if (cur_x >= lim_x) last = 1;
				else cur_x = cur_x + 1'b1;
			end
		endcase
		if (last) begin
			walk = KIND_IDLE;
			r.shape_last = 1'b1;
		end
		r.walk_busy = walk != KIND_IDLE;
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(99) < 70) return 0;
		if ($urandom_range(99) < 85) return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	// valid stays high after an accepted beat until the next gap or a drain
	task automatic send_beat(in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixel_queue.push_back(predict_pixel(it));
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= PaddrBits'(8 * idx); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_BASE: cfg.base_address = value[AddrBits-1:0];
			REG_PITCH: cfg.line_pitch = value[PitchBits-1:0];
			REG_WIDTH: cfg.screen_width = value[CoordBits-1:0];
			REG_HEIGHT: cfg.screen_height = value[CoordBits-1:0];
			REG_PIXB: cfg.pixel_bytes = value[2:0];
			REG_RED: cfg.red_shift = value[4:0];
			REG_GREEN: cfg.green_shift = value[4:0];
			default: cfg.blue_shift = value[4:0];
		endcase
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_screen(logic [63:0] base, int pitch, int w, int h, int pb,
			int rs, int gs, int bs);
		wait_drained();
		write_reg(REG_BASE, base);
		write_reg(REG_PITCH, 64'(pitch));
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
		write_reg(REG_PIXB, 64'(pb));
		write_reg(REG_RED, 64'(rs));
		write_reg(REG_GREEN, 64'(gs));
		write_reg(REG_BLUE, 64'(bs));
	endtask

	function automatic in_item_t make_beat(cmd_t c, int x0, int y0, int x1, int y1);
		in_item_t it;
		it.command = c;
		it.point_x = CoordBits'(x0); it.point_y = CoordBits'(y0);
		it.far_x = CoordBits'(x1); it.far_y = CoordBits'(y1);
		it.red = 8'($urandom); it.green = 8'($urandom); it.blue = 8'($urandom);
		return it;
	endfunction

	task automatic steps(int n);
		repeat (n) send_beat(make_beat(CMD_STEP, $urandom, $urandom, $urandom, $urandom));
	endtask

	task automatic test_directed();
		// steps while idle, and the unused command
		send_beat(make_beat(CMD_STEP, 8191, 8191, 8191, 8191));
		send_beat(make_beat(CMD_NONE, 0, 0, 0, 0));
		set_screen(48'hFFFF_FFFF_FFF0, 65535, 8, 6, 3, 31, 24, 0);
		send_beat(make_beat(CMD_RECT, 6, 4, 5, 5));     // clipped at both edges
		steps(5);
		send_beat(make_beat(CMD_RECT, 8191, 8191, 8191, 8191)); // empty area
		send_beat(make_beat(CMD_LINE, 2, 1, 2, 7));     // vertical downward, runs off screen
		steps(7);
		send_beat(make_beat(CMD_LINE, 3, 5, 3, 0));     // vertical upward
		steps(3);
		send_beat(make_beat(CMD_LINE, 0, 5, 7, 0));     // sloped, negative rise
		steps(3);
		send_beat(make_beat(CMD_LINE, 0, 0, 4, 8191));  // abandon old shape, steep slope
		steps(2);
		send_beat(make_beat(CMD_LINE, 5, 0, 1, 3));     // reversed: nothing drawn
		steps(1);
	endtask

	task automatic random_phase(int n);
		int k;
		int c;
		int w, h;
		k = 0;
		w = cfg.screen_width + 4;
		h = cfg.screen_height + 4;
		while (k < n) begin
			c = $urandom_range(99);
			if (c < 12)
				send_beat(make_beat(CMD_RECT, $urandom_range(w), $urandom_range(h),
					$urandom_range(6), $urandom_range(6)));
			else if (c < 20)
				send_beat(make_beat(CMD_LINE, $urandom_range(w), $urandom_range(h),
					$urandom_range(w), $urandom_range(h)));
			else if (c < 23)
				send_beat(make_beat(cmd_t'($urandom_range(3)), $urandom, $urandom,
					$urandom, $urandom));
			else
				steps(1);
			k++;
		end
	endtask

	task automatic test_random();
		set_screen({$urandom, $urandom}, $urandom_range(200, 1), 24, 16, 4, 16, 8, 0);
		random_phase(300);
		set_screen({$urandom, $urandom}, $urandom, 40, 30, 3, $urandom, $urandom, $urandom);
		random_phase(300);
		// quiet receiver: no output stalls during these phases
		stall_quiet = 1'b1;
		set_screen(48'h0, 0, 8191, 8191, 0, 0, 0, 31);
		random_phase(100);
		set_screen(48'hFFFF_FFFF_FFFF, 65535, 16, 12, 7, 31, 31, 31);
		random_phase(150);
		stall_quiet = 1'b0;
		set_screen($urandom, $urandom_range(100), 20, 20, 1, 3, 11, 22);
		random_phase(200);
		wait_drained();
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		out_item_t exp_px;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pixel_queue.size() == 0) begin
					$error("pixel beat with nothing expected");
					errors++;
				end else begin
					exp_px = pixel_queue.pop_front();
					if (out_item.write_valid !== exp_px.write_valid) begin
						$error("write_valid exp %0h got %0h", exp_px.write_valid,
							out_item.write_valid);
						errors++;
					end
					if (out_item.write_address !== exp_px.write_address) begin
						$error("write_address exp %0h got %0h", exp_px.write_address,
							out_item.write_address);
						errors++;
					end
					if (out_item.pixel_value !== exp_px.pixel_value) begin
						$error("pixel_value exp %0h got %0h", exp_px.pixel_value,
							out_item.pixel_value);
						errors++;
					end
					if (out_item.walk_busy !== exp_px.walk_busy) begin
						$error("walk_busy exp %0h got %0h", exp_px.walk_busy,
							out_item.walk_busy);
						errors++;
					end
					if (out_item.shape_last !== exp_px.shape_last) begin
						$error("shape_last exp %0h got %0h", exp_px.shape_last,
							out_item.shape_last);
						errors++;
					end
				end
			end
			if (stall_quiet)
				out_stall <= 1'b0;
			else if ($urandom_range(99) < 3)
				out_stall <= 1'b1;
			else if ($urandom_range(99) < 35)
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		stall_quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
